>>> design/rczm_pkg.sv
`timescale 1ns / 1ps

package rczm_pkg;

    // Fixed-point format and frame limits
    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int CFG_W     = 17;

    // Zoom is Q4.12, pan is Q1.16
    localparam logic [15:0] ZOOM_MIN  = 16'd410;
    localparam logic [15:0] ZOOM_MAX  = 16'd32768;
    localparam int          ZOOM_SH   = 12;
    localparam logic [16:0] PAN_ONE   = 17'd65536;

    // Shared divider: 41-bit dividend, 16-bit divisor
    localparam int DIV_N_W  = 41;
    localparam int DIV_D_W  = 16;
    localparam int RECIP_SH = 24;

    // Derived widths
    localparam int FULL_W = DIM_W + FRAC_BITS;   // source size in Q.16
    localparam int CROP_W = 32;                  // zoomed crop size
    localparam int ORG_W  = 34;                  // signed crop origin
    localparam int REC_W  = RECIP_SH + 1;

    localparam logic [CROP_W-1:0] CROP_ONE = CROP_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_ROTATION      = 3'd4,
        CFG_ZOOM          = 3'd5,
        CFG_PAN_X         = 3'd6,
        CFG_PAN_Y         = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [3:0] {
        SU_FIT,
        SU_ZW,
        SU_ZH,
        SU_AX,
        SU_AY,
        SU_RX,
        SU_RY,
        SU_CTR,
        SU_ORG,
        SU_READY
    } setup_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } in_item_t;

    typedef struct packed {
        logic               inside_res;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
    } out_item_t;

    // Per-configuration values handed from setup to the item pipeline
    typedef struct packed {
        logic              ready;
        rot_t              rot;
        logic [DIM_W-1:0]  tw;
        logic [DIM_W-1:0]  th;
        logic [DIM_W-1:0]  lw;
        logic [DIM_W-1:0]  lh;
        logic [FULL_W-1:0] full_w;
        logic [FULL_W-1:0] full_h;
        logic [CROP_W-1:0] ax;
        logic [CROP_W-1:0] ay;
        logic [DIM_W-1:0]  bx;
        logic [DIM_W-1:0]  by;
        logic [REC_W-1:0]  rx;
        logic [REC_W-1:0]  ry;
        logic [ORG_W-1:0]  org_x;
        logic [ORG_W-1:0]  org_y;
    } derived_t;

    // Read a size of 0 as 1 and clip above the frame limit
    function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    // Keep a crop size at one pixel or more
    function automatic logic [CROP_W-1:0] at_least_one(input logic [DIV_N_W-1:0] q);
        logic [CROP_W-1:0] r;
        if (q < DIV_N_W'(CROP_ONE))
            r = CROP_ONE;
        else
            r = q[CROP_W-1:0];
        return r;
    endfunction

endpackage

>>> design/rczm_stream_if.sv
`timescale 1ns / 1ps

interface rczm_stream_if import rczm_pkg::*; #(parameter type payload_t = in_item_t);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/rczm_div.sv
`timescale 1ns / 1ps

module rczm_div import rczm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient,
    output logic [DIV_D_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;

    // One restoring step: shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_N_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    // Sequence control; a start restarts any division in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_N_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> design/rczm_setup.sv
`timescale 1ns / 1ps

module rczm_setup import rczm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output derived_t         derived
);

    // Configuration registers
    logic [DIM_W-1:0] src_w_reg;
    logic [DIM_W-1:0] src_h_reg;
    logic [DIM_W-1:0] tgt_w_reg;
    logic [DIM_W-1:0] tgt_h_reg;
    rot_t             rot_reg;
    logic [15:0]      zoom_reg;
    logic [16:0]      pan_x_reg;
    logic [16:0]      pan_y_reg;

    setup_state_t state_reg, state_next;
    logic         issued_reg, issued_next;
    setup_state_t after_div;
    logic         is_div;

    logic [FULL_W-1:0] fit_reg;
    logic [CROP_W-1:0] cw_reg, ch_reg;
    logic [CROP_W-1:0] ax_reg, ay_reg;
    logic [DIM_W-1:0]  bx_reg, by_reg;
    logic [REC_W-1:0]  rx_reg, ry_reg;
    logic [29:0]       cx_reg, cy_reg;
    logic [ORG_W-1:0]  org_x_reg, org_y_reg;

    logic [DIM_W-1:0]   sw, sh, tw, th, lw, lh;
    logic [2*DIM_W-1:0] prod_a, prod_b;
    logic               wide;
    logic [15:0]        zc;
    logic [16:0]        px_c, py_c;
    logic [FULL_W-1:0]  full_w, full_h;
    logic [FULL_W-1:0]  cw0, ch0;

    logic               div_start;
    logic               div_done;
    logic               div_take;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic [DIV_N_W-1:0] div_quo;
    logic [DIV_D_W-1:0] div_rem;
    logic [CROP_W-1:0]  crop_q;

    logic [ORG_W-1:0]  org_x_next, org_y_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= DIM_W'(1);
            src_h_reg <= DIM_W'(1);
            tgt_w_reg <= DIM_W'(1);
            tgt_h_reg <= DIM_W'(1);
            rot_reg   <= ROT_0;
            zoom_reg  <= 16'd4096;
            pan_x_reg <= 17'd32768;
            pan_y_reg <= 17'd32768;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SOURCE_WIDTH:  src_w_reg <= cfg_data[DIM_W-1:0];
                CFG_SOURCE_HEIGHT: src_h_reg <= cfg_data[DIM_W-1:0];
                CFG_TARGET_WIDTH:  tgt_w_reg <= cfg_data[DIM_W-1:0];
                CFG_TARGET_HEIGHT: tgt_h_reg <= cfg_data[DIM_W-1:0];
                CFG_ROTATION:      rot_reg   <= rot_t'(cfg_data[1:0]);
                CFG_ZOOM:          zoom_reg  <= cfg_data[15:0];
                CFG_PAN_X:         pan_x_reg <= cfg_data;
                CFG_PAN_Y:         pan_y_reg <= cfg_data;
            endcase
        end
    end

    // Clipped sizes, logical target size and aspect decision
    always_comb
    begin
        sw     = fit_dim(src_w_reg);
        sh     = fit_dim(src_h_reg);
        tw     = fit_dim(tgt_w_reg);
        th     = fit_dim(tgt_h_reg);
        lw     = rot_reg[0] ? th : tw;
        lh     = rot_reg[0] ? tw : th;
        prod_a = sw * lh;
        prod_b = lw * sh;
        wide   = prod_a > prod_b;
        if (zoom_reg < ZOOM_MIN)
            zc = ZOOM_MIN;
        else if (zoom_reg > ZOOM_MAX)
            zc = ZOOM_MAX;
        else
            zc = zoom_reg;
        px_c   = (pan_x_reg > PAN_ONE) ? PAN_ONE : pan_x_reg;
        py_c   = (pan_y_reg > PAN_ONE) ? PAN_ONE : pan_y_reg;
        full_w = {sw, FRAC_BITS'(0)};
        full_h = {sh, FRAC_BITS'(0)};
        cw0    = wide ? fit_reg : full_w;
        ch0    = wide ? full_h : fit_reg;
    end

    // Pick the operands for the division of the current step
    always_comb
    begin
        div_num = '0;
        div_den = DIV_D_W'(1);
        unique case (state_reg)
            SU_FIT:
            begin
                div_num = wide ? DIV_N_W'({prod_b[24:0], FRAC_BITS'(0)})
                               : DIV_N_W'({prod_a[24:0], FRAC_BITS'(0)});
                div_den = wide ? DIV_D_W'(lh) : DIV_D_W'(lw);
            end
            SU_ZW:
            begin
                div_num = DIV_N_W'({cw0, ZOOM_SH'(0)});
                div_den = zc;
            end
            SU_ZH:
            begin
                div_num = DIV_N_W'({ch0, ZOOM_SH'(0)});
                div_den = zc;
            end
            SU_AX:
            begin
                div_num = DIV_N_W'(cw_reg);
                div_den = DIV_D_W'(lw);
            end
            SU_AY:
            begin
                div_num = DIV_N_W'(ch_reg);
                div_den = DIV_D_W'(lh);
            end
            SU_RX:
            begin
                div_num = DIV_N_W'(1) << RECIP_SH;
                div_den = DIV_D_W'(lw);
            end
            SU_RY:
            begin
                div_num = DIV_N_W'(1) << RECIP_SH;
                div_den = DIV_D_W'(lh);
            end
            SU_CTR, SU_ORG, SU_READY:
            begin
                div_num = '0;
            end
        endcase
    end

    rczm_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer: issue each division, wait for it, then step on
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        is_div      = 1'b1;
        after_div   = SU_READY;
        unique case (state_reg)
            SU_FIT:   after_div = SU_ZW;
            SU_ZW:    after_div = SU_ZH;
            SU_ZH:    after_div = SU_AX;
            SU_AX:    after_div = SU_AY;
            SU_AY:    after_div = SU_RX;
            SU_RX:    after_div = SU_RY;
            SU_RY:    after_div = SU_CTR;
            SU_CTR:
            begin
                is_div     = 1'b0;
                state_next = SU_ORG;
            end
            SU_ORG:
            begin
                is_div     = 1'b0;
                state_next = SU_READY;
            end
            SU_READY: is_div = 1'b0;
        endcase
        div_start = is_div && !issued_reg;
        div_take  = is_div && issued_reg && div_done;
        if (div_start)
            issued_next = 1'b1;
        else if (div_take)
        begin
            issued_next = 1'b0;
            state_next  = after_div;
        end
        // Any configuration write starts the derivation over
        if (cfg_write)
        begin
            state_next  = SU_FIT;
            issued_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SU_FIT;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    assign crop_q = at_least_one(div_quo);

    // Clamp the centered crop origin inside the source when the crop fits
    always_comb
    begin
        org_x_next = ORG_W'({4'b0, cx_reg}) - ORG_W'({3'b0, cw_reg[CROP_W-1:1]});
        if ({3'b0, full_w} >= cw_reg)
        begin
            if (org_x_next[ORG_W-1])
                org_x_next = '0;
            else if (org_x_next > ORG_W'(CROP_W'(full_w) - cw_reg))
                org_x_next = ORG_W'(CROP_W'(full_w) - cw_reg);
        end
        org_y_next = ORG_W'({4'b0, cy_reg}) - ORG_W'({3'b0, ch_reg[CROP_W-1:1]});
        if ({3'b0, full_h} >= ch_reg)
        begin
            if (org_y_next[ORG_W-1])
                org_y_next = '0;
            else if (org_y_next > ORG_W'(CROP_W'(full_h) - ch_reg))
                org_y_next = ORG_W'(CROP_W'(full_h) - ch_reg);
        end
    end

    // Capture step results
    always_ff @(posedge clk)
    begin
        if (div_take)
        begin
            case (state_reg)
                SU_FIT: fit_reg <= crop_q[FULL_W-1:0];
                SU_ZW:  cw_reg  <= crop_q;
                SU_ZH:  ch_reg  <= crop_q;
                SU_AX:
                begin
                    ax_reg <= div_quo[CROP_W-1:0];
                    bx_reg <= div_rem[DIM_W-1:0];
                end
                SU_AY:
                begin
                    ay_reg <= div_quo[CROP_W-1:0];
                    by_reg <= div_rem[DIM_W-1:0];
                end
                SU_RX:  rx_reg  <= div_quo[REC_W-1:0];
                SU_RY:  ry_reg  <= div_quo[REC_W-1:0];
                default: ;
            endcase
        end
        if (state_reg == SU_CTR)
        begin
            cx_reg <= px_c * sw;
            cy_reg <= py_c * sh;
        end
        if (state_reg == SU_ORG)
        begin
            org_x_reg <= org_x_next;
            org_y_reg <= org_y_next;
        end
    end

    always_comb
    begin
        derived.ready  = state_reg == SU_READY;
        derived.rot    = rot_reg;
        derived.tw     = tw;
        derived.th     = th;
        derived.lw     = lw;
        derived.lh     = lh;
        derived.full_w = full_w;
        derived.full_h = full_h;
        derived.ax     = ax_reg;
        derived.ay     = ay_reg;
        derived.bx     = bx_reg;
        derived.by     = by_reg;
        derived.rx     = rx_reg;
        derived.ry     = ry_reg;
        derived.org_x  = org_x_reg;
        derived.org_y  = org_y_reg;
    end

endmodule

>>> design/rczm_pipe.sv
`timescale 1ns / 1ps

module rczm_pipe import rczm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  derived_t      derived,
    rczm_stream_if.sink   coord,
    rczm_stream_if.source sample
);

    logic advance;
    logic take;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;

    // Stage 1: rotated logical coordinate
    logic [COORD_W-1:0] lx1_reg, ly1_reg;
    logic               out1_reg;
    // Stage 2: whole and fractional products
    logic [CROP_W-1:0]  px2_reg, py2_reg;
    logic [23:0]        nx2_reg, ny2_reg;
    logic               out2_reg;
    // Stage 3: reciprocal quotient estimate
    logic [CROP_W-1:0]  px3_reg, py3_reg;
    logic [23:0]        nx3_reg, ny3_reg;
    logic [DIM_W-1:0]   qx3_reg, qy3_reg;
    logic               out3_reg;
    // Stage 4: corrected quotient
    logic [CROP_W-1:0]  px4_reg, py4_reg;
    logic [DIM_W-1:0]   qx4_reg, qy4_reg;
    logic               out4_reg;
    out_item_t          res_reg;

    logic [DIM_W-1:0]   x13, y13, lx13, ly13;
    logic               outside;
    logic [43:0]        px_full, py_full;
    logic [24:0]        nx_full, ny_full;
    logic [48:0]        tx, ty;
    logic [25:0]        mx, my, rx_err, ry_err;
    logic [DIM_W-1:0]   qx_fix, qy_fix;
    logic [ORG_W:0]     sx, sy;
    logic               in_frame;

    // Hold the whole line while a finished item waits to be taken
    assign advance      = !out_v_reg || sample.ready;
    assign coord.ready  = advance && derived.ready;
    assign take         = coord.valid && coord.ready;

    // Undo the rotation and flag points off the target
    always_comb
    begin
        x13     = {1'b0, coord.data.out_x};
        y13     = {1'b0, coord.data.out_y};
        outside = (x13 >= derived.tw) || (y13 >= derived.th);
        lx13    = x13;
        ly13    = y13;
        unique case (derived.rot)
            ROT_0:
            begin
                lx13 = x13;
                ly13 = y13;
            end
            ROT_90:
            begin
                lx13 = y13;
                ly13 = derived.tw - DIM_W'(1) - x13;
            end
            ROT_180:
            begin
                lx13 = derived.tw - DIM_W'(1) - x13;
                ly13 = derived.th - DIM_W'(1) - y13;
            end
            ROT_270:
            begin
                lx13 = derived.th - DIM_W'(1) - y13;
                ly13 = x13;
            end
        endcase
    end

    // Split lx*cw/lw into lx*(cw div lw) plus lx*(cw mod lw)/lw
    always_comb
    begin
        px_full = lx1_reg * derived.ax;
        py_full = ly1_reg * derived.ay;
        nx_full = lx1_reg * derived.bx;
        ny_full = ly1_reg * derived.by;
    end

    // Estimate the small quotient by reciprocal; it is low by one at most
    always_comb
    begin
        tx = nx2_reg * derived.rx;
        ty = ny2_reg * derived.ry;
    end

    // Correct the estimate with one compare
    always_comb
    begin
        mx     = qx3_reg * derived.lw;
        my     = qy3_reg * derived.lh;
        rx_err = {2'b0, nx3_reg} - mx;
        ry_err = {2'b0, ny3_reg} - my;
        qx_fix = qx3_reg + DIM_W'(rx_err >= 26'(derived.lw));
        qy_fix = qy3_reg + DIM_W'(ry_err >= 26'(derived.lh));
    end

    // Add the crop origin and test against the source frame
    always_comb
    begin
        sx = {derived.org_x[ORG_W-1], derived.org_x} + (ORG_W+1)'(px4_reg)
             + (ORG_W+1)'(qx4_reg);
        sy = {derived.org_y[ORG_W-1], derived.org_y} + (ORG_W+1)'(py4_reg)
             + (ORG_W+1)'(qy4_reg);
        in_frame = !out4_reg && !sx[ORG_W] && !sy[ORG_W]
                   && (sx[ORG_W-1:0] < ORG_W'(derived.full_w))
                   && (sy[ORG_W-1:0] < ORG_W'(derived.full_h));
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg    <= take;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            out_v_reg <= v4_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lx1_reg  <= lx13[COORD_W-1:0];
            ly1_reg  <= ly13[COORD_W-1:0];
            out1_reg <= outside;

            px2_reg  <= px_full[CROP_W-1:0];
            py2_reg  <= py_full[CROP_W-1:0];
            nx2_reg  <= nx_full[23:0];
            ny2_reg  <= ny_full[23:0];
            out2_reg <= out1_reg;

            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            qx3_reg  <= tx[RECIP_SH+DIM_W-1:RECIP_SH];
            qy3_reg  <= ty[RECIP_SH+DIM_W-1:RECIP_SH];
            out3_reg <= out2_reg;

            px4_reg  <= px3_reg;
            py4_reg  <= py3_reg;
            qx4_reg  <= qx_fix;
            qy4_reg  <= qy_fix;
            out4_reg <= out3_reg;

            res_reg.inside_res <= in_frame;
            res_reg.src_x <= in_frame ? sx[FRAC_BITS+COORD_W-1:FRAC_BITS] : '0;
            res_reg.src_y <= in_frame ? sy[FRAC_BITS+COORD_W-1:FRAC_BITS] : '0;
        end
    end

    assign sample.valid = out_v_reg;
    assign sample.data  = res_reg;

endmodule

>>> design/rotate_crop_zoom_coordinate_map.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while sample.ready and setup allow it.
// The five-stage multiply pipeline stalls as a whole.
// Setup: after reset and after every configuration write, a serial divider derives
// the crop values, during which coord.ready stays low.
// Reset: rst_n is asynchronous, active low; it empties the pipeline and loads defaults.
module rotate_crop_zoom_coordinate_map import rczm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    rczm_stream_if.sink      coord,
    rczm_stream_if.source    sample
);

    derived_t derived;

    // Derive per-configuration crop values
    rczm_setup u_setup
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .derived   (derived)
    );

    // Map each coordinate item
    rczm_pipe u_pipe
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .derived (derived),
        .coord   (coord),
        .sample  (sample)
    );

endmodule

>>> design/rczm_checker.sv
`timescale 1ns / 1ps

module rczm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic        coord_ready,
    input logic        sample_valid,
    input logic        sample_ready,
    input logic        inside_res,
    input logic [11:0] src_x,
    input logic [11:0] src_y
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(inside_res)
            && $stable(src_x) && $stable(src_y))
        else $error("stalled result changed");

    // A configuration write restarts setup, so no item is taken right after
    a_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !coord_ready)
        else $error("item accepted right after configuration write");

    // Points off the frame report zero coordinates
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !inside_res |-> src_x == 12'd0 && src_y == 12'd0)
        else $error("outside result with nonzero coordinates");

endmodule

bind rotate_crop_zoom_coordinate_map rczm_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_write),
    .coord_ready  (coord.ready),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .inside_res   (sample.data.inside_res),
    .src_x        (sample.data.src_x),
    .src_y        (sample.data.src_y)
);

>>> tb/rczm_map_checker.sv
`timescale 1ns / 1ps

module rczm_map_checker import rczm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic        coord_valid,
    input  logic        coord_ready,
    input  in_item_t    coord_data,
    input  logic        sample_valid,
    input  logic        sample_ready,
    input  out_item_t   sample_data,
    output int          fail_count,
    output int          pending
);

    logic [12:0] src_w, src_h, tgt_w, tgt_h;
    logic [1:0]  rot_q;
    logic [15:0] zoom_q;
    logic [16:0] pan_xq, pan_yq;
    out_item_t   sample_queue[$];

    assign pending = sample_queue.size();

    function automatic longint clip_dim(input logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    function automatic longint min_one(input longint v);
        return (v < 65536) ? 65536 : v;
    endfunction

    // Crop origin on one axis, clamped inside the frame when the crop fits
    function automatic longint origin(input logic [16:0] pan, input longint sz,
                                      input longint crop);
        longint p, ctr, org, full;
        p = (pan > PAN_ONE) ? 65536 : pan;
        ctr = ((p * sz) << 16) >> 16;
        org = ctr - (crop >>> 1);
        full = sz << 16;
        if (crop <= full)
        begin
            if (org < 0)
                org = 0;
            if (org > full - crop)
                org = full - crop;
        end
        return org;
    endfunction

    function automatic out_item_t map_coord(input in_item_t c);
        out_item_t r;
        longint sw, sh, tw, th, lw, lh, lx, ly, cw, ch, z, sx, sy;
        r = '0;
        sw = clip_dim(src_w);
        sh = clip_dim(src_h);
        tw = clip_dim(tgt_w);
        th = clip_dim(tgt_h);
        lx = c.out_x;
        ly = c.out_y;
        lw = tw;
        lh = th;
        if (c.out_x >= tw || c.out_y >= th)
            return r;
        case (rot_t'(rot_q))
            ROT_90:
            begin
                lw = th; lh = tw; lx = c.out_y; ly = tw - 1 - c.out_x;
            end
            ROT_270:
            begin
                lw = th; lh = tw; lx = th - 1 - c.out_y; ly = c.out_x;
            end
            ROT_180:
            begin
                lx = tw - 1 - c.out_x; ly = th - 1 - c.out_y;
            end
            default: ;
        endcase
        if (sw * lh > lw * sh)
        begin
            cw = min_one(((sh * lw) << 16) / lh);
            ch = sh << 16;
        end
        else
        begin
            cw = sw << 16;
            ch = min_one(((sw * lh) << 16) / lw);
        end
        z = zoom_q;
        if (z < ZOOM_MIN)
            z = ZOOM_MIN;
        if (z > ZOOM_MAX)
            z = ZOOM_MAX;
        cw = min_one(cw * 4096 / z);
        ch = min_one(ch * 4096 / z);
        sx = origin(pan_xq, sw, cw) + lx * cw / lw;
        sy = origin(pan_yq, sh, ch) + ly * ch / lh;
        if (sx < 0 || sy < 0 || sx >= (sw << 16) || sy >= (sh << 16))
            return r;
        r.inside_res = 1'b1;
        r.src_x = sx[27:16];
        r.src_y = sy[27:16];
        return r;
    endfunction

    // Track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            src_w <= 1; src_h <= 1; tgt_w <= 1; tgt_h <= 1;
            rot_q <= 0; zoom_q <= 16'd4096;
            pan_xq <= 17'd32768; pan_yq <= 17'd32768;
            sample_queue.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SOURCE_WIDTH:  src_w <= cfg_data[12:0];
                    CFG_SOURCE_HEIGHT: src_h <= cfg_data[12:0];
                    CFG_TARGET_WIDTH:  tgt_w <= cfg_data[12:0];
                    CFG_TARGET_HEIGHT: tgt_h <= cfg_data[12:0];
                    CFG_ROTATION:      rot_q <= cfg_data[1:0];
                    CFG_ZOOM:          zoom_q <= cfg_data[15:0];
                    CFG_PAN_X:         pan_xq <= cfg_data;
                    CFG_PAN_Y:         pan_yq <= cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
            begin
                if (sample_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", sample_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (want !== sample_data)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected in=%0d x=%0d y=%0d, got in=%0d x=%0d y=%0d",
                                     want.inside_res, want.src_x, want.src_y,
                                     sample_data.inside_res, sample_data.src_x,
                                     sample_data.src_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (coord_valid && coord_ready)
                sample_queue.push_back(map_coord(coord_data));
        end
    end

endmodule

>>> tb/tb_rotate_crop_zoom_coordinate_map.sv
`timescale 1ns / 1ps

module tb_rotate_crop_zoom_coordinate_map;
    import rczm_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [2:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    logic [12:0] tw_now, th_now;

    rczm_stream_if #(.payload_t(in_item_t))  coord();
    rczm_stream_if #(.payload_t(out_item_t)) sample();

    rotate_crop_zoom_coordinate_map dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .coord(coord.sink), .sample(sample.source)
    );

    rczm_map_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .coord_valid(coord.valid), .coord_ready(coord.ready),
        .coord_data(coord.data), .sample_valid(sample.valid),
        .sample_ready(sample.ready), .sample_data(sample.data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: count cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((coord.valid && coord.ready) || (sample.valid && sample.ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stalls, sometimes none
    initial
    begin
        int gap;
        sample.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            repeat (gap) @(posedge clk);
            sample.ready <= 1'b1;
            do
                @(posedge clk);
            while (!sample.valid);
            sample.ready <= 1'b0;
        end
    end

    // Wait until every predicted result has come back
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write one register once nothing is in flight
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_TARGET_WIDTH)
            tw_now = val[12:0];
        if (idx == CFG_TARGET_HEIGHT)
            th_now = val[12:0];
    endtask

    // Send one coordinate; gap drawn per item unless told not to idle
    task automatic send_coord(input logic [11:0] x, input logic [11:0] y,
                              input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 11);
        repeat (gap) @(posedge clk);
        coord.valid <= 1'b1;
        coord.data  <= '{out_x: x, out_y: y};
        do
            @(posedge clk);
        while (!coord.ready);
        coord.valid <= 1'b0;
    endtask

    function automatic logic [12:0] rand_dim();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'h1FFF;
            4: return 13'($urandom_range(1, 64));
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    // Pick a coordinate mostly inside the target, sometimes beyond it
    task automatic send_random(input bit no_gap);
        logic [11:0] x, y;
        int tw, th;
        tw = (tw_now == 0) ? 1 : (tw_now > 4096 ? 4096 : tw_now);
        th = (th_now == 0) ? 1 : (th_now > 4096 ? 4096 : th_now);
        if ($urandom_range(0, 7) == 0)
        begin
            x = 12'($urandom);
            y = 12'($urandom);
        end
        else
        begin
            x = 12'($urandom_range(0, tw - 1));
            y = 12'($urandom_range(0, th - 1));
        end
        send_coord(x, y, no_gap);
    endtask

    initial
    begin
        int burst;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        coord.valid = 1'b0;
        coord.data = '0;
        tw_now = 1;
        th_now = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults, then every rotation on a small frame
        send_coord(12'd0, 12'd0, 1'b0);
        send_coord(12'd1, 12'd0, 1'b0);
        write_reg(CFG_SOURCE_WIDTH, 17'd16);
        write_reg(CFG_SOURCE_HEIGHT, 17'd9);
        write_reg(CFG_TARGET_WIDTH, 17'd8);
        write_reg(CFG_TARGET_HEIGHT, 17'd6);
        for (int r = 0; r < 4; r++)
        begin
            write_reg(CFG_ROTATION, 17'(r));
            send_coord(12'd0, 12'd0, 1'b0);
            send_coord(12'd7, 12'd5, 1'b0);
            send_coord(12'd8, 12'd0, 1'b0);
            send_coord(12'd0, 12'd6, 1'b0);
        end
        drain();

        // Directed: zoom and pan extremes, sizes of 0 and above the limit
        write_reg(CFG_ZOOM, 17'd0);
        write_reg(CFG_PAN_X, 17'h1FFFF);
        write_reg(CFG_PAN_Y, 17'd0);
        write_reg(CFG_SOURCE_WIDTH, 17'd0);
        write_reg(CFG_SOURCE_HEIGHT, 17'h1FFF);
        write_reg(CFG_TARGET_WIDTH, 17'h1FFF);
        write_reg(CFG_TARGET_HEIGHT, 17'd4096);
        send_coord(12'd0, 12'd0, 1'b0);
        send_coord(12'hFFF, 12'hFFF, 1'b0);
        drain();
        write_reg(CFG_ZOOM, 17'hFFFF);
        send_coord(12'hFFF, 12'd0, 1'b0);
        send_coord(12'd0, 12'hFFF, 1'b0);
        drain();

        // Random phases: new settings, then a run of coordinates
        for (int ph = 0; ph < 16; ph++)
        begin
            write_reg(CFG_SOURCE_WIDTH, 17'(rand_dim()));
            write_reg(CFG_SOURCE_HEIGHT, 17'(rand_dim()));
            write_reg(CFG_TARGET_WIDTH, 17'(rand_dim()));
            write_reg(CFG_TARGET_HEIGHT, 17'(rand_dim()));
            write_reg(CFG_ROTATION, 17'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_ZOOM, 17'($urandom_range(0, 65535)));
                1: write_reg(CFG_ZOOM, 17'($urandom_range(300, 500)));
                default: write_reg(CFG_ZOOM, 17'($urandom_range(2048, 16384)));
            endcase
            write_reg(CFG_PAN_X, ($urandom_range(0, 7) == 0) ? 17'h1FFFF
                                  : 17'($urandom_range(0, 65536)));
            write_reg(CFG_PAN_Y, ($urandom_range(0, 7) == 0) ? 17'h1FFFF
                                  : 17'($urandom_range(0, 65536)));
            burst = $urandom_range(0, 1);
            for (int i = 0; i < 48; i++)
                send_random(burst == 1 && i < 24);
            // Hold off until the results of this phase are all back
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
